@@ hw/rtl/kbst_pkg.sv @@
package kbst_pkg;

    // default table capacity
    localparam int ENTRIES_DEF = 64;

    // fixed field widths
    localparam int OP_W      = 3;
    localparam int ID_W      = 16;
    localparam int CH_W      = 8;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 7;

    // operation codes, unnamed codes change nothing
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_WRITE  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ZERO_ID   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ_CMP,
        S_DONE
    } t_state;

    // one table entry
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [CH_W-1:0] ch;
        logic            st;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_scan;
        logic    rd_pos;
        logic    wr_state;
        logic    wr_append;
        logic    wr_shift;
        logic    count_inc;
        logic    count_dec;
        logic    count_clr;
        logic    res_load;
        t_status res_status;
        logic    res_state;
        logic    res_entry;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_op  op;
        logic id_zero;
        logic scan_end;
        logic match;
        logic pos_ok;
        logic full;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/kbst_dp.sv @@
module kbst_dp #(
    parameter int ENTRIES = kbst_pkg::ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kbst_pkg::t_dp_cmd                i_cmd,
    output kbst_pkg::t_dp_sts                o_sts,
    input  logic [kbst_pkg::OP_W-1:0]        i_op,
    input  logic [kbst_pkg::ID_W-1:0]        i_key_id,
    input  logic [kbst_pkg::CH_W-1:0]        i_key_channel,
    input  logic                             i_write_state,
    input  logic [kbst_pkg::POS_W-1:0]       i_position,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [kbst_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_state_value,
    output logic [kbst_pkg::ID_W-1:0]        o_entry_key_id,
    output logic [kbst_pkg::CH_W-1:0]        o_entry_key_channel,
    output logic [kbst_pkg::ECOUNT_W-1:0]    o_entry_count
);
    import kbst_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // table storage, one write and one read port
    t_entry r_mem [ENTRIES];

    // captured item
    t_op              r_op;
    logic [ID_W-1:0]  r_id;
    logic [CH_W-1:0]  r_ch;
    logic             r_wst;
    logic [POS_W-1:0] r_pos;

    // walk index and fill count
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] n_count;

    t_entry r_rd_data;

    // staged result and output register
    t_status         r_res_status;
    logic            r_res_sval;
    logic [ID_W-1:0] r_res_eid;
    logic [CH_W-1:0] r_res_ech;

    logic                r_out_valid;
    t_status             r_out_status;
    logic                r_out_sval;
    logic [ID_W-1:0]     r_out_eid;
    logic [CH_W-1:0]     r_out_ech;
    logic [ECOUNT_W-1:0] r_out_count;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             wr_en;
    logic             rd_en;
    t_entry           key_entry;

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_id  <= i_key_id;
            r_ch  <= i_key_channel;
            r_wst <= i_write_state;
            r_pos <= i_position;
        end
    end

    // walk index and count next values
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
        n_count = r_count;
        if (i_cmd.count_clr) begin
            n_count = '0;
        end else if (i_cmd.count_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.count_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    // memory port selection
    always_comb begin
        key_entry = '{id: r_id, ch: r_ch, st: r_wst};
        rd_en     = i_cmd.rd_scan | i_cmd.rd_pos;
        rd_addr   = i_cmd.rd_pos ? IDX_W'(CMP_W'(r_pos)) : IDX_W'(r_idx);
        wr_en     = i_cmd.wr_state | i_cmd.wr_append | i_cmd.wr_shift;
        wr_addr   = IDX_W'(r_idx);
        wr_data   = key_entry;
        if (i_cmd.wr_append) begin
            wr_addr = IDX_W'(r_count);
        end else if (i_cmd.wr_shift) begin
            wr_addr = IDX_W'(r_idx - 1'b1);
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_sval   <= i_cmd.res_state ? r_rd_data.st : 1'b0;
            r_res_eid    <= i_cmd.res_entry ? r_rd_data.id : '0;
            r_res_ech    <= i_cmd.res_entry ? r_rd_data.ch : '0;
        end
    end

    // output register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_sval   <= r_res_sval;
            r_out_eid    <= r_res_eid;
            r_out_ech    <= r_res_ech;
            r_out_count  <= ECOUNT_W'(r_count);
        end
    end

    // status towards the controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.id_zero  = (r_id == '0);
        o_sts.scan_end = (r_idx == r_count);
        o_sts.match    = (r_rd_data.id == r_id) && (r_rd_data.ch == r_ch);
        o_sts.pos_ok   = (CMP_W'(r_pos) < CMP_W'(r_count));
        o_sts.full     = (r_count == CNT_W'(ENTRIES));
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_state_value       = r_out_sval;
    assign o_entry_key_id      = r_out_eid;
    assign o_entry_key_channel = r_out_ech;
    assign o_entry_count       = r_out_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled item");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr_state, i_cmd.wr_append, i_cmd.wr_shift}))
        else $error("more than one table write at once");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_scan |-> (r_idx < r_count))
        else $error("table read beyond the valid entries");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_inc |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the count");
`endif

endmodule

@@ hw/rtl/kbst_ctrl.sv @@
module kbst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kbst_pkg::t_dp_sts i_sts,
    output kbst_pkg::t_dp_cmd o_cmd
);
    import kbst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op) inside
                    OP_LOOKUP, OP_REMOVE: n_state = S_SCAN_RD;
                    OP_WRITE: n_state = i_sts.id_zero ? S_DONE : S_SCAN_RD;
                    OP_READ:  n_state = i_sts.pos_ok ? S_READ_CMP : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SCAN_RD: begin
                n_state = i_sts.scan_end ? S_DONE : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (!i_sts.match) begin
                    n_state = S_SCAN_RD;
                end else if (i_sts.op == OP_REMOVE) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                n_state = i_sts.scan_end ? S_DONE : S_SHIFT_WR;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_READ_CMP: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.idx_clr = 1'b1;
                unique case (i_sts.op) inside
                    OP_LOOKUP, OP_REMOVE: begin
                    end
                    OP_WRITE: begin
                        if (i_sts.id_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_ZERO_ID;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.pos_ok) begin
                            o_cmd.rd_pos = 1'b1;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NOT_FOUND;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.count_clr = 1'b1;
                        o_cmd.res_load  = 1'b1;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (!i_sts.scan_end) begin
                    o_cmd.rd_scan = 1'b1;
                end else if (i_sts.op != OP_WRITE) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                end else if (i_sts.full) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_FULL;
                end else begin
                    // key is new, append it at the end
                    o_cmd.wr_append = 1'b1;
                    o_cmd.count_inc = 1'b1;
                    o_cmd.res_load  = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (!i_sts.match) begin
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    unique case (i_sts.op) inside
                        OP_LOOKUP: begin
                            o_cmd.res_load  = 1'b1;
                            o_cmd.res_state = 1'b1;
                        end
                        OP_WRITE: begin
                            o_cmd.wr_state = 1'b1;
                            o_cmd.res_load = 1'b1;
                        end
                        OP_REMOVE: begin
                            o_cmd.idx_inc = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.res_load  = 1'b1;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_SHIFT_WR: begin
                // move the entry one place down
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            S_READ_CMP: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_state = 1'b1;
                o_cmd.res_entry = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hw/rtl/keyed_binary_state_table.sv @@
// Keyed state table: an insertion-ordered list of entries (id, channel, state)
// with lookup, write (update or append), remove with compaction, read by
// position and clear.
// Input channel: i_in_valid / o_in_stall carry one command item with op,
// key_id, key_channel, write_state and position. An item is taken when
// valid is high and stall is low; stall is low only while the block is idle.
// Output channel: o_out_valid / i_out_stall carry exactly one result item per
// command: status, state_value, entry_key_id, entry_key_channel, entry_count.
// After an item is taken, clear, zero-id writes, unused ops and reads past
// the end load their result straight from decode; a read in range first
// reads the entry at its position. Lookup and write walk the table one entry
// at a time, a read state then a compare state per entry. Remove walks to the
// key, then moves each later entry one place down, read then write per entry.
// The walk is set by the single read port of the entry memory.
// The next item is taken at the edge after the result is loaded into the
// output register, even while the receiver stalls; the following result
// then waits until the held one is taken.
// Reset (synchronous, active low) empties the table and drops any held
// result; entry storage itself is not cleared.
module keyed_binary_state_table #(
    parameter int ENTRIES = kbst_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kbst_pkg::OP_W-1:0]     i_op,
    input  logic [kbst_pkg::ID_W-1:0]     i_key_id,
    input  logic [kbst_pkg::CH_W-1:0]     i_key_channel,
    input  logic                          i_write_state,
    input  logic [kbst_pkg::POS_W-1:0]    i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kbst_pkg::STATUS_W-1:0] o_status,
    output logic                          o_state_value,
    output logic [kbst_pkg::ID_W-1:0]     o_entry_key_id,
    output logic [kbst_pkg::CH_W-1:0]     o_entry_key_channel,
    output logic [kbst_pkg::ECOUNT_W-1:0] o_entry_count
);
    import kbst_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    kbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table memory, count and result registers
    kbst_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_op                (i_op),
        .i_key_id            (i_key_id),
        .i_key_channel       (i_key_channel),
        .i_write_state       (i_write_state),
        .i_position          (i_position),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_state_value       (o_state_value),
        .o_entry_key_id      (o_entry_key_id),
        .o_entry_key_channel (o_entry_key_channel),
        .o_entry_count       (o_entry_count)
    );

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kbst_pkg::*;

    localparam int TABLE_DEPTH = ENTRIES_DEF;
    localparam int NO_SLOT = -1;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam int SPARE_OPS = 3;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int FILL_BURST = TABLE_DEPTH + 6;

    // one command item and one result item
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [CH_W-1:0]  ch;
        logic             ws;
        logic [POS_W-1:0] pos;
    } t_table_cmd;

    typedef struct packed {
        t_status               status;
        logic                  sval;
        logic [ID_W-1:0]       eid;
        logic [CH_W-1:0]       ech;
        logic [ECOUNT_W-1:0]   count;
    } t_table_resp;

    // shadow copy of the table and the queue of results still owed
    class t_state_table_scoreboard;
        logic [ID_W-1:0] slot_id [TABLE_DEPTH];
        logic [CH_W-1:0] slot_ch [TABLE_DEPTH];
        logic            slot_st [TABLE_DEPTH];
        int              used;
        t_table_resp     owed_q[$];
        int              errors;

        function new();
            used = 0;
            errors = 0;
        endfunction

        function int find_slot(logic [ID_W-1:0] id, logic [CH_W-1:0] ch);
            for (int i = 0; i < used; i++) begin
                if (slot_id[i] == id && slot_ch[i] == ch) return i;
            end
            return NO_SLOT;
        endfunction

        // apply an accepted command to the shadow table, queue its result
        function void note_command(t_table_cmd c);
            t_table_resp r;
            int hit;
            r = '0;
            r.status = ST_OK;
            hit = find_slot(c.id, c.ch);
            case (c.op)
                OP_LOOKUP: begin
                    if (hit != NO_SLOT) r.sval = slot_st[hit];
                    else r.status = ST_NOT_FOUND;
                end
                OP_WRITE: begin
                    if (c.id == '0) begin
                        r.status = ST_ZERO_ID;
                    end else if (hit != NO_SLOT) begin
                        slot_st[hit] = c.ws;
                    end else if (used >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_id[used] = c.id;
                        slot_ch[used] = c.ch;
                        slot_st[used] = c.ws;
                        used++;
                    end
                end
                OP_REMOVE: begin
                    if (hit != NO_SLOT) begin
                        // close the gap left by the removed entry
                        for (int j = hit + 1; j < used; j++) begin
                            slot_id[j-1] = slot_id[j];
                            slot_ch[j-1] = slot_ch[j];
                            slot_st[j-1] = slot_st[j];
                        end
                        used--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                OP_READ: begin
                    if (int'(c.pos) < used) begin
                        r.sval = slot_st[c.pos];
                        r.eid = slot_id[c.pos];
                        r.ech = slot_ch[c.pos];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR: begin
                    used = 0;
                end
                default: begin
                end
            endcase
            r.count = ECOUNT_W'(used);
            owed_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
            if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // compare a delivered result with the oldest one owed
        task check_result(t_table_resp got);
            t_table_resp want;
            if (owed_q.size() == 0) begin
                report("result item with no command outstanding");
                return;
            end
            want = owed_q.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("state_value", got.sval, want.sval);
            compare_field("entry_key_id", got.eid, want.eid);
            compare_field("entry_key_channel", got.ech, want.ech);
            compare_field("entry_count", got.count, want.count);
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op = '0;
    logic [ID_W-1:0]     i_key_id = '0;
    logic [CH_W-1:0]     i_key_channel = '0;
    logic                i_write_state = 1'b0;
    logic [POS_W-1:0]    i_position = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic                o_state_value;
    logic [ID_W-1:0]     o_entry_key_id;
    logic [CH_W-1:0]     o_entry_key_channel;
    logic [ECOUNT_W-1:0] o_entry_count;

    t_state_table_scoreboard sb = new();

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    keyed_binary_state_table #(
        .ENTRIES(TABLE_DEPTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_key_id           (i_key_id),
        .i_key_channel      (i_key_channel),
        .i_write_state      (i_write_state),
        .i_position         (i_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_state_value      (o_state_value),
        .o_entry_key_id     (o_entry_key_id),
        .o_entry_key_channel(o_entry_key_channel),
        .o_entry_count      (o_entry_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_table_cmd make_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                            logic [CH_W-1:0] ch, logic ws,
                                            logic [POS_W-1:0] pos);
        t_table_cmd c;
        c.op = op;
        c.id = id;
        c.ch = ch;
        c.ws = ws;
        c.pos = pos;
        return c;
    endfunction

    // write of a fresh nonzero key, used to push the table to full
    function automatic t_table_cmd fresh_write();
        return make_cmd(OP_WRITE, ID_W'($urandom_range(65535, 1)), CH_W'($urandom_range(255)),
                        1'($urandom_range(1)), POS_W'($urandom()));
    endfunction

    // random command, keys mostly taken from entries currently held
    function automatic t_table_cmd random_command(bit fill_bias);
        t_table_cmd c;
        int r;
        int idx;
        r = $urandom_range(99);
        if (fill_bias) begin
            if (r < 55) c.op = OP_WRITE;
            else if (r < 75) c.op = OP_LOOKUP;
            else if (r < 83) c.op = OP_REMOVE;
            else if (r < 96) c.op = OP_READ;
            else c.op = OP_SPARE_FIRST + OP_W'($urandom_range(SPARE_OPS - 1));
        end else begin
            if (r < 30) c.op = OP_WRITE;
            else if (r < 52) c.op = OP_LOOKUP;
            else if (r < 78) c.op = OP_REMOVE;
            else if (r < 93) c.op = OP_READ;
            else if (r < 96) c.op = OP_CLEAR;
            else c.op = OP_SPARE_FIRST + OP_W'($urandom_range(SPARE_OPS - 1));
        end
        c.ws = 1'($urandom_range(1));
        // position mostly inside the filled part
        if (sb.used > 0 && $urandom_range(99) < 60) c.pos = POS_W'($urandom_range(sb.used - 1));
        else c.pos = POS_W'($urandom_range(TABLE_DEPTH - 1));
        r = $urandom_range(99);
        c.ch = CH_W'($urandom_range(255));
        if (sb.used > 0 && r < 55) begin
            idx = $urandom_range(sb.used - 1);
            c.id = sb.slot_id[idx];
            c.ch = sb.slot_ch[idx];
        end else if (sb.used > 0 && r < 65) begin
            // held id on another channel
            idx = $urandom_range(sb.used - 1);
            c.id = sb.slot_id[idx];
        end else if (r < 68) begin
            c.id = '0;
        end else begin
            c.id = ID_W'($urandom_range(65535));
        end
        return c;
    endfunction

    // offer one command item, return at the edge where it is taken
    task automatic send_command(t_table_cmd c);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= c.op;
        i_key_id <= c.id;
        i_key_channel <= c.ch;
        i_write_state <= c.ws;
        i_position <= c.pos;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(c);
    endtask

    // result side: check taken items, then choose next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(t_table_resp'({o_status, o_state_value, o_entry_key_id,
                                           o_entry_key_channel, o_entry_count}));
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, directed items, then random phases
    initial begin
        t_table_cmd dir_q[$];
        int mode;
        bit fill;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, zero id, update, near miss, shifts, spare ops, clear
        dir_q.push_back(make_cmd(OP_LOOKUP, 16'h1234, 8'h56, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_REMOVE, 16'hFFFF, 8'hFF, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_WRITE, 16'h0000, 8'hFF, 1'b1, 6'd63));
        dir_q.push_back(make_cmd(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, 6'd0));
        dir_q.push_back(make_cmd(OP_WRITE, 16'h0001, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_WRITE, 16'h8000, 8'h80, 1'b1, 6'd0));
        dir_q.push_back(make_cmd(OP_LOOKUP, 16'hFFFF, 8'hFF, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_LOOKUP, 16'hFFFF, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_WRITE, 16'hFFFF, 8'hFF, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_LOOKUP, 16'hFFFF, 8'hFF, 1'b1, 6'd0));
        dir_q.push_back(make_cmd(OP_READ, 16'hFFFF, 8'hFF, 1'b1, 6'd0));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd2));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd3));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd63));
        dir_q.push_back(make_cmd(OP_SPARE_FIRST, 16'hFFFF, 8'hFF, 1'b1, 6'd63));
        dir_q.push_back(make_cmd(OP_SPARE_FIRST + 3'd1, 16'h0001, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_SPARE_FIRST + 3'd2, 16'hFFFF, 8'hFF, 1'b1, 6'd1));
        dir_q.push_back(make_cmd(OP_REMOVE, 16'hFFFF, 8'hFF, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_READ, 16'h0000, 8'h00, 1'b0, 6'd1));
        dir_q.push_back(make_cmd(OP_REMOVE, 16'h8000, 8'h80, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_REMOVE, 16'h8000, 8'h80, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_CLEAR, 16'h0000, 8'h00, 1'b0, 6'd0));
        dir_q.push_back(make_cmd(OP_LOOKUP, 16'h0001, 8'h00, 1'b0, 6'd0));
        foreach (dir_q[i]) send_command(dir_q[i]);

        // random phases: idling mode and fill or drain bias vary
        for (int ph = 0; ph < PHASES; ph++) begin
            mode = ph % 4;
            fill = (ph < 4) ? (ph % 2 == 0) : (ph % 2 == 1);
            send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 7 : 0;
            recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 7 : 0;
            // long receiver hold-off while items keep coming
            if (ph == 0) hold_req = 1'b1;
            if (fill) begin
                repeat (FILL_BURST) send_command(fresh_write());
                repeat (PHASE_ITEMS - FILL_BURST) send_command(random_command(1'b1));
            end else begin
                repeat (PHASE_ITEMS) send_command(random_command(1'b0));
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        recv_stall_pct = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
